// ===== rtl/two_link_inverse_kinematics_macros.svh =====
// Assertion macros shared by the two-link inverse kinematics RTL.
// Files that assert include this header; the macros expect clk and rst in scope.
`ifndef TWO_LINK_INVERSE_KINEMATICS_MACROS_SVH
`define TWO_LINK_INVERSE_KINEMATICS_MACROS_SVH
// Same-cycle implication, off during reset.
`define TLIK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, off during reset.
`define TLIK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/tlik_pkg.sv =====
// Shared constants, types and tables for the two-link inverse kinematics block.
// No dependencies; every RTL module imports this package.
package tlik_pkg;

  localparam int COORD_W      = 24;
  localparam int LEN_W        = 23;
  localparam int NZL_W        = 16;
  localparam int ANG_W        = 16;
  localparam int ANGX_W       = ANG_W + 1;
  localparam int DIST_W       = 25;
  localparam int DATA_W       = 32;
  localparam int PADDR_W      = 4;
  localparam int SQ_IN_W      = 62;
  localparam int SQ_OUT_W     = SQ_IN_W / 2;
  localparam int DIV_W        = 52;
  localparam int DIV_STEPS    = 30;
  localparam int RATIO_W      = DIV_STEPS + 2;
  localparam int CORDIC_STEPS = 20;
  localparam int CORDIC_W     = 34;
  localparam int CZ_W         = 24;
  localparam int FRONT_LAT    = SQ_OUT_W + 3;
  localparam int DIV_LAT      = DIV_STEPS + 1;
  localparam int ACOS_LAT     = SQ_OUT_W + CORDIC_STEPS + 3;
  localparam int SB_LEN       = DIV_LAT + ACOS_LAT;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = 2;
  localparam int QCNT_W       = 3;

  localparam logic signed [ANGX_W-1:0] ANG_PI            = ANGX_W'(12868);
  localparam logic signed [ANGX_W-1:0] ANG_HALF_PI       = ANGX_W'(6434);
  localparam logic signed [ANGX_W-1:0] ANG_THREE_HALF_PI = ANGX_W'(19302);

  localparam logic [LEN_W-1:0] LINK_RESET = LEN_W'(256);
  localparam logic [NZL_W-1:0] NZL_RESET  = NZL_W'(1);

  typedef enum logic [1:0] {
    REG_LINK_ONE  = 2'd0,
    REG_LINK_TWO  = 2'd1,
    REG_NEAR_ZERO = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [LEN_W-1:0] link_one;
    logic [LEN_W-1:0] link_two;
    logic [NZL_W-1:0] near_zero;
  } ik_cfg_t;

  // Request handed from the front end to the back end.
  typedef struct packed {
    logic                      x_pos;
    logic                      z_pos;
    logic signed [COORD_W-1:0] z;
    logic [DIST_W-1:0]         t;
    logic [DIST_W-1:0]         d;
  } front_item_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } queue_status_t;

  // atan(2^-i) in units of 2^-20 rad
  function automatic logic signed [CZ_W-1:0] atan_entry(input int unsigned idx);
    logic signed [CZ_W-1:0] v;
    case (idx)
      0:  v = CZ_W'(823550);
      1:  v = CZ_W'(486170);
      2:  v = CZ_W'(256879);
      3:  v = CZ_W'(130396);
      4:  v = CZ_W'(65451);
      5:  v = CZ_W'(32757);
      6:  v = CZ_W'(16383);
      7:  v = CZ_W'(8192);
      8:  v = CZ_W'(4096);
      9:  v = CZ_W'(2048);
      10: v = CZ_W'(1024);
      11: v = CZ_W'(512);
      12: v = CZ_W'(256);
      13: v = CZ_W'(128);
      14: v = CZ_W'(64);
      15: v = CZ_W'(32);
      16: v = CZ_W'(16);
      17: v = CZ_W'(8);
      18: v = CZ_W'(4);
      19: v = CZ_W'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/tlik_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on tlik_pkg.
module tlik_sqrt
  import tlik_pkg::*;
(
  input  logic                clk,
  input  logic                en,
  input  logic [SQ_IN_W-1:0]  radicand,
  output logic [SQ_OUT_W-1:0] root
);

  logic [SQ_IN_W-1:0] rem [SQ_OUT_W];
  logic [SQ_IN_W-1:0] res [SQ_OUT_W];

  genvar k;
  generate
    for (k = 0; k < SQ_OUT_W; k++) begin : g_step
      localparam logic [SQ_IN_W-1:0] BIT = SQ_IN_W'(1) << (SQ_IN_W - 2 - 2 * k);
      logic [SQ_IN_W-1:0] rem_in;
      logic [SQ_IN_W-1:0] res_in;
      logic [SQ_IN_W-1:0] trial;
      if (k == 0) begin : g_first
        assign rem_in = radicand;
        assign res_in = '0;
      end else begin : g_rest
        assign rem_in = rem[k-1];
        assign res_in = res[k-1];
      end
      assign trial = res_in + BIT;
      always_ff @(posedge clk) begin
        if (en) begin
          if (rem_in >= trial) begin
            rem[k] <= rem_in - trial;
            res[k] <= (res_in >> 1) + BIT;
          end else begin
            rem[k] <= rem_in;
            res[k] <= res_in >> 1;
          end
        end
      end
    end
  endgenerate

  assign root = res[SQ_OUT_W-1][SQ_OUT_W-1:0];

endmodule

// ===== rtl/tlik_div.sv =====
// Pipelined Q30 ratio num/den, clamped to [-1,1], one quotient bit per stage.
// Depends on tlik_pkg.
module tlik_div
  import tlik_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [DIV_W:0]     num,
  input  logic [DIV_W-1:0]          den,
  output logic signed [RATIO_W-1:0] ratio
);

  typedef struct packed {
    logic                 neg;
    logic                 zero;
    logic                 sat;
    logic [DIV_W-1:0]     r;
    logic [DIV_W-1:0]     den;
    logic [DIV_STEPS-1:0] q;
  } div_stage_t;

  div_stage_t       st [DIV_STEPS+1];
  logic [DIV_W:0]   num_mag;
  logic [RATIO_W-1:0] q_abs;

  assign num_mag = num[DIV_W] ? (DIV_W+1)'(-num) : (DIV_W+1)'(num);

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].neg  <= num[DIV_W];
      st[0].zero <= (num == '0);
      st[0].sat  <= (den == '0) || (num_mag >= {1'b0, den});
      st[0].r    <= num_mag[DIV_W-1:0];
      st[0].den  <= den;
      st[0].q    <= '0;
    end
  end

  genvar j;
  generate
    for (j = 1; j <= DIV_STEPS; j++) begin : g_step
      logic [DIV_W:0] r2;
      logic           ge;
      assign r2 = {st[j-1].r, 1'b0};
      assign ge = (r2 >= {1'b0, st[j-1].den});
      always_ff @(posedge clk) begin
        if (en) begin
          st[j].neg  <= st[j-1].neg;
          st[j].zero <= st[j-1].zero;
          st[j].sat  <= st[j-1].sat;
          st[j].den  <= st[j-1].den;
          st[j].r    <= ge ? DIV_W'(r2 - {1'b0, st[j-1].den}) : r2[DIV_W-1:0];
          st[j].q    <= {st[j-1].q[DIV_STEPS-2:0], ge};
        end
      end
    end
  endgenerate

  assign q_abs = st[DIV_STEPS].sat ? (RATIO_W'(1) << DIV_STEPS)
                                   : RATIO_W'(st[DIV_STEPS].q);

  always_comb begin
    if (st[DIV_STEPS].zero) begin
      ratio = '0;
    end else if (st[DIV_STEPS].neg) begin
      ratio = -$signed(q_abs);
    end else begin
      ratio = $signed(q_abs);
    end
  end

endmodule

// ===== rtl/tlik_acos.sv =====
// Pipelined arccosine: sqrt(1-c^2), then CORDIC vectoring; out in [0, PI].
// Depends on tlik_pkg and tlik_sqrt.
module tlik_acos
  import tlik_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [RATIO_W-1:0] cosv,
  output logic [ANG_W-1:0]          angle
);

  localparam logic [SQ_IN_W-1:0] ONE_SQ = SQ_IN_W'(1) << (2 * DIV_STEPS);

  logic signed [2*RATIO_W-1:0] sq_full;
  logic signed [RATIO_W-1:0]   c0;
  logic signed [RATIO_W-1:0]   c1;
  logic [SQ_IN_W-1:0]          sq0;
  logic [SQ_IN_W-1:0]          rad1;
  logic [SQ_OUT_W-1:0]         root;
  logic signed [RATIO_W-1:0]   cdly [SQ_OUT_W];
  logic signed [CORDIC_W-1:0]  cx [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0]  cy [CORDIC_STEPS+1];
  logic signed [CZ_W-1:0]      cz [CORDIC_STEPS+1];
  logic signed [CZ_W-1:0]      zr;
  logic signed [CZ_W-1:0]      rnd;

  assign sq_full = cosv * cosv;

  always_ff @(posedge clk) begin
    if (en) begin
      c0   <= cosv;
      sq0  <= sq_full[SQ_IN_W-1:0];
      c1   <= c0;
      rad1 <= ONE_SQ - sq0;
    end
  end

  tlik_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (rad1),
    .root     (root)
  );

  // c rides alongside the root pipeline
  genvar k;
  generate
    for (k = 0; k < SQ_OUT_W; k++) begin : g_cdly
      always_ff @(posedge clk) begin
        if (en) begin
          if (k == 0) begin
            cdly[k] <= c1;
          end else begin
            cdly[k] <= cdly[(k == 0) ? 0 : k-1];
          end
        end
      end
    end
  endgenerate

  // negative cosine: start from the quarter turn so the vector stays right of y
  always_ff @(posedge clk) begin
    if (en) begin
      if (cdly[SQ_OUT_W-1] < 0) begin
        cx[0] <= CORDIC_W'({1'b0, root});
        cy[0] <= -(CORDIC_W'(cdly[SQ_OUT_W-1]));
        cz[0] <= CZ_W'(ANG_HALF_PI) <<< 8;
      end else begin
        cx[0] <= CORDIC_W'(cdly[SQ_OUT_W-1]);
        cy[0] <= CORDIC_W'({1'b0, root});
        cz[0] <= '0;
      end
    end
  end

  genvar i;
  generate
    for (i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      always_ff @(posedge clk) begin
        if (en) begin
          if (cy[i] > 0) begin
            cx[i+1] <= cx[i] + (cy[i] >>> i);
            cy[i+1] <= cy[i] - (cx[i] >>> i);
            cz[i+1] <= cz[i] + atan_entry(i);
          end else begin
            cx[i+1] <= cx[i] - (cy[i] >>> i);
            cy[i+1] <= cy[i] + (cx[i] >>> i);
            cz[i+1] <= cz[i] - atan_entry(i);
          end
        end
      end
    end
  endgenerate

  assign zr  = cz[CORDIC_STEPS] + CZ_W'(128);
  assign rnd = zr >>> 8;

  always_comb begin
    if (rnd < 0) begin
      angle = '0;
    end else if (rnd > CZ_W'(ANG_PI)) begin
      angle = ANG_PI[ANG_W-1:0];
    end else begin
      angle = rnd[ANG_W-1:0];
    end
  end

endmodule

// ===== rtl/tlik_front.sv =====
// Front end: takes goal requests, squares the coordinates and finds t and d.
// Depends on tlik_pkg and tlik_sqrt.
module tlik_front
  import tlik_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      goal_valid,
  output logic                      goal_ready,
  input  logic signed [COORD_W-1:0] goal_x,
  input  logic signed [COORD_W-1:0] goal_y,
  input  logic signed [COORD_W-1:0] goal_z,
  output logic                      item_valid,
  input  logic                      item_ready,
  output front_item_t               item
);

  typedef struct packed {
    logic                      x_pos;
    logic                      z_pos;
    logic signed [COORD_W-1:0] z;
  } front_sb_t;

  logic                      en;
  logic [FRONT_LAT-1:0]      vpipe;
  front_sb_t                 sb [FRONT_LAT];
  logic signed [COORD_W-1:0] x0, y0, z0;
  logic [2*COORD_W-1:0]      xx, yy, zz;
  logic [SQ_IN_W-1:0]        sum_t, sum_d;
  logic [SQ_OUT_W-1:0]       root_t, root_d;

  // whole front advances together; it freezes only when the queue is full
  assign en         = !item_valid || item_ready;
  assign goal_ready = en;
  assign item_valid = vpipe[FRONT_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[FRONT_LAT-2:0], goal_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb[0] <= '{x_pos: (goal_x > 0), z_pos: (goal_z > 0), z: goal_z};
      x0    <= goal_x;
      y0    <= goal_y;
      z0    <= goal_z;
      xx    <= x0 * x0;
      yy    <= y0 * y0;
      zz    <= z0 * z0;
      sum_t <= SQ_IN_W'(xx) + SQ_IN_W'(zz);
      sum_d <= SQ_IN_W'(xx) + SQ_IN_W'(zz) + SQ_IN_W'(yy);
    end
  end

  genvar k;
  generate
    for (k = 1; k < FRONT_LAT; k++) begin : g_sb
      always_ff @(posedge clk) begin
        if (en) begin
          sb[k] <= sb[k-1];
        end
      end
    end
  endgenerate

  tlik_sqrt u_sqrt_t (
    .clk      (clk),
    .en       (en),
    .radicand (sum_t),
    .root     (root_t)
  );

  tlik_sqrt u_sqrt_d (
    .clk      (clk),
    .en       (en),
    .radicand (sum_d),
    .root     (root_d)
  );

  assign item.x_pos = sb[FRONT_LAT-1].x_pos;
  assign item.z_pos = sb[FRONT_LAT-1].z_pos;
  assign item.z     = sb[FRONT_LAT-1].z;
  assign item.t     = root_t[DIST_W-1:0];
  assign item.d     = root_d[DIST_W-1:0];

endmodule

// ===== rtl/tlik_queue.sv =====
// Short request queue between front and back ends.
// Depends on tlik_pkg.
module tlik_queue
  import tlik_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  front_item_t   in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output front_item_t   out_item,
  output queue_status_t status
);

  front_item_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push, pop;

  assign status.empty = (count == '0);
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.count = count;
  assign in_ready     = !status.full;
  assign out_valid    = !status.empty;
  assign out_item     = slots[rd_ptr];
  assign push         = in_valid && in_ready;
  assign pop          = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

// ===== rtl/tlik_back.sv =====
// Back end: special cases, four ratios and four arccosines, angle assembly.
// Depends on tlik_pkg, tlik_div and tlik_acos.
module tlik_back
  import tlik_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  ik_cfg_t                 cfg,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  front_item_t             item,
  output logic                    angle_valid,
  input  logic                    angle_ready,
  output logic signed [ANG_W-1:0] base_yaw,
  output logic signed [ANG_W-1:0] base_pitch,
  output logic signed [ANG_W-1:0] elbow_angle
);

  typedef struct packed {
    logic x_pos;
    logic z_pos;
    logic t_zero;
    logic d_zero;
    logic reach;
  } back_sb_t;

  logic                      en;
  // stage 0
  logic                      v0;
  logic signed [COORD_W-1:0] z0;
  logic [DIST_W-1:0]         t0, d0;
  back_sb_t                  f0;
  logic [2*LEN_W-1:0]        p_l1l1, p_l2l2, p_l1l2;
  logic [2*DIST_W-1:0]       p_dd;
  logic [LEN_W+DIST_W-1:0]   p_l1d;
  // stage 1
  logic                      v1;
  back_sb_t                  f1;
  logic signed [DIV_W:0]     num_yaw, num_g, num_tang, num_inner;
  logic [DIV_W-1:0]          den_yaw, den_g, den_tang, den_inner;
  // ratio and angle units
  logic signed [RATIO_W-1:0] r_yaw, r_g, r_tang, r_inner;
  logic [ANG_W-1:0]          a_yaw, a_g, a_tang, a_inner;
  // sideband line
  logic [SB_LEN-1:0]         vsb;
  back_sb_t                  sb [SB_LEN];
  back_sb_t                  fl;
  logic signed [ANGX_W-1:0]  ay, ag, at, ai;
  logic signed [ANGX_W-1:0]  yaw_c, pitch_c, elbow_c;

  assign en         = !angle_valid || angle_ready;
  assign item_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0          <= 1'b0;
      v1          <= 1'b0;
      vsb         <= '0;
      angle_valid <= 1'b0;
    end else if (en) begin
      v0          <= item_valid;
      v1          <= v0;
      vsb         <= {vsb[SB_LEN-2:0], v1};
      angle_valid <= vsb[SB_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z0        <= item.z;
      t0        <= item.t;
      d0        <= item.d;
      f0.x_pos  <= item.x_pos;
      f0.z_pos  <= item.z_pos;
      f0.t_zero <= (item.t == '0) || (item.t < DIST_W'(cfg.near_zero));
      f0.d_zero <= (item.d == '0) || (item.d < DIST_W'(cfg.near_zero));
      f0.reach  <= (item.d >= (DIST_W'(cfg.link_one) + DIST_W'(cfg.link_two)));
      p_l1l1    <= cfg.link_one * cfg.link_one;
      p_l2l2    <= cfg.link_two * cfg.link_two;
      p_l1l2    <= cfg.link_one * cfg.link_two;
      p_dd      <= item.d * item.d;
      p_l1d     <= cfg.link_one * item.d;

      f1        <= f0;
      num_yaw   <= (DIV_W+1)'(z0);
      den_yaw   <= DIV_W'(t0);
      num_g     <= (DIV_W+1)'(t0);
      den_g     <= DIV_W'(d0);
      num_tang  <= (DIV_W+1)'(p_l1l1) + (DIV_W+1)'(p_dd) - (DIV_W+1)'(p_l2l2);
      den_tang  <= DIV_W'({p_l1d, 1'b0});
      num_inner <= (DIV_W+1)'(p_l1l1) + (DIV_W+1)'(p_l2l2) - (DIV_W+1)'(p_dd);
      den_inner <= DIV_W'({p_l1l2, 1'b0});
    end
  end

  tlik_div u_div_yaw   (.clk(clk), .en(en), .num(num_yaw),   .den(den_yaw),   .ratio(r_yaw));
  tlik_div u_div_g     (.clk(clk), .en(en), .num(num_g),     .den(den_g),     .ratio(r_g));
  tlik_div u_div_tang  (.clk(clk), .en(en), .num(num_tang),  .den(den_tang),  .ratio(r_tang));
  tlik_div u_div_inner (.clk(clk), .en(en), .num(num_inner), .den(den_inner), .ratio(r_inner));

  tlik_acos u_acos_yaw   (.clk(clk), .en(en), .cosv(r_yaw),   .angle(a_yaw));
  tlik_acos u_acos_g     (.clk(clk), .en(en), .cosv(r_g),     .angle(a_g));
  tlik_acos u_acos_tang  (.clk(clk), .en(en), .cosv(r_tang),  .angle(a_tang));
  tlik_acos u_acos_inner (.clk(clk), .en(en), .cosv(r_inner), .angle(a_inner));

  genvar k;
  generate
    for (k = 0; k < SB_LEN; k++) begin : g_sb
      always_ff @(posedge clk) begin
        if (en) begin
          if (k == 0) begin
            sb[k] <= f1;
          end else begin
            sb[k] <= sb[(k == 0) ? 0 : k-1];
          end
        end
      end
    end
  endgenerate

  assign fl = sb[SB_LEN-1];
  assign ay = ANGX_W'(a_yaw);
  assign ag = ANGX_W'(a_g);
  assign at = ANGX_W'(a_tang);
  assign ai = ANGX_W'(a_inner);

  always_comb begin
    if (fl.t_zero) begin
      yaw_c = '0;
    end else if (fl.x_pos) begin
      yaw_c = ay - ANG_HALF_PI;
    end else if (fl.z_pos) begin
      yaw_c = -ANG_HALF_PI - ay;
    end else begin
      yaw_c = ANG_THREE_HALF_PI - ay;
    end
    if (fl.d_zero) begin
      pitch_c = '0;
      elbow_c = '0;
    end else if (fl.reach) begin
      pitch_c = ANG_HALF_PI - ag;
      elbow_c = '0;
    end else begin
      pitch_c = ANG_HALF_PI - ag - at;
      elbow_c = ANG_PI - ai;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base_yaw    <= yaw_c[ANG_W-1:0];
      base_pitch  <= pitch_c[ANG_W-1:0];
      elbow_angle <= elbow_c[ANG_W-1:0];
    end
  end

endmodule

// ===== rtl/two_link_inverse_kinematics.sv =====
// Throughput: one goal per cycle while neither end stalls;
// the sqrt, divide and CORDIC units are fully pipelined.
// The front end stalls only on a full 4-entry queue, the back end only on angle_ready.
// Reset (rst, synchronous) empties the pipelines and queue and sets link lengths
// to 256 and the near-zero limit to 1; no clearing pass is needed.
`include "two_link_inverse_kinematics_macros.svh"

module two_link_inverse_kinematics
  import tlik_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // APB-style register port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready,
  // goal requests
  input  logic                      goal_valid,
  output logic                      goal_ready,
  input  logic signed [COORD_W-1:0] goal_x,
  input  logic signed [COORD_W-1:0] goal_y,
  input  logic signed [COORD_W-1:0] goal_z,
  // angle requests
  output logic                      angle_valid,
  input  logic                      angle_ready,
  output logic signed [ANG_W-1:0]   base_yaw,
  output logic signed [ANG_W-1:0]   base_pitch,
  output logic signed [ANG_W-1:0]   elbow_angle
);

  ik_cfg_t       cfg;
  reg_idx_t      reg_idx;
  logic          reg_write;
  logic          front_valid, front_ready;
  front_item_t   front_item;
  logic          q_valid, back_ready;
  front_item_t   q_item;
  queue_status_t q_status;

  // Registers at byte addresses 0, 4, 8; writes land on the access cycle.
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.link_one  <= LINK_RESET;
      cfg.link_two  <= LINK_RESET;
      cfg.near_zero <= NZL_RESET;
    end else if (reg_write) begin
      case (reg_idx)
        REG_LINK_ONE:  cfg.link_one  <= pwdata[LEN_W-1:0];
        REG_LINK_TWO:  cfg.link_two  <= pwdata[LEN_W-1:0];
        REG_NEAR_ZERO: cfg.near_zero <= pwdata[NZL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LINK_ONE:  prdata = DATA_W'(cfg.link_one);
      REG_LINK_TWO:  prdata = DATA_W'(cfg.link_two);
      REG_NEAR_ZERO: prdata = DATA_W'(cfg.near_zero);
      default:       prdata = '0;
    endcase
  end

  // Front end: squares and the two distance roots.
  tlik_front u_front (
    .clk        (clk),
    .rst        (rst),
    .goal_valid (goal_valid),
    .goal_ready (goal_ready),
    .goal_x     (goal_x),
    .goal_y     (goal_y),
    .goal_z     (goal_z),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item       (front_item)
  );

  // Decouples the two stall domains.
  tlik_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_item   (front_item),
    .out_valid (q_valid),
    .out_ready (back_ready),
    .out_item  (q_item),
    .status    (q_status)
  );

  // Back end: ratios, arccosines, quadrant and reach handling.
  tlik_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_valid  (q_valid),
    .item_ready  (back_ready),
    .item        (q_item),
    .angle_valid (angle_valid),
    .angle_ready (angle_ready),
    .base_yaw    (base_yaw),
    .base_pitch  (base_pitch),
    .elbow_angle (elbow_angle)
  );

  `TLIK_ASSERT_NOW(a_elbow_range, angle_valid, (elbow_angle >= 0) && (elbow_angle <= ANG_PI[ANG_W-1:0]), "elbow angle outside [0, pi]")
  `TLIK_ASSERT_NOW(a_yaw_range, angle_valid, (base_yaw >= -ANG_THREE_HALF_PI) && (base_yaw <= ANG_THREE_HALF_PI), "base yaw outside range")
  `TLIK_ASSERT_NOW(a_front_stall, front_valid && q_status.full, !goal_ready, "front accepted a goal with the queue full")
  `TLIK_ASSERT_NEXT(a_queue_hold, q_status.full && !back_ready, q_status.full, "queue drained without a pop")

endmodule
